// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the bridge table RTL.
// Each macro expects aclk and aresetn in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on a property, muted while in reset.
`define MLBT_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("mlbt assertion failed");

// Same-cycle implication.
`define MLBT_ASSERT_IMP(label, ante, cons) \
    `MLBT_ASSERT(label, (ante) |-> (cons))

// Next-cycle implication.
`define MLBT_ASSERT_NXT(label, ante, cons) \
    `MLBT_ASSERT(label, (ante) |=> (cons))

`endif

// ----- rtl/mlbt_pkg.sv -----
// Types and constants for the MAC learning bridge table.
// Used by mlbt_cell and mac_learning_bridge_table_unit; no dependencies.
package mlbt_pkg;

    localparam int CAPACITY     = 64;
    localparam int CELL_ENTRIES = 8;
    localparam int NUM_CELLS    = CAPACITY / CELL_ENTRIES;
    localparam int IDX_W        = $clog2(CAPACITY);
    localparam int LOCAL_W      = $clog2(CELL_ENTRIES);
    localparam int CELL_W       = $clog2(NUM_CELLS);
    localparam int LCNT_W       = LOCAL_W + 1;

    localparam int MAC_W   = 48;
    localparam int PORT_W  = 8;
    localparam int TIME_W  = 32;
    localparam int COUNT_W = 7;
    localparam int SUM_W   = COUNT_W + 1;

    localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;
    localparam logic [TIME_W-1:0]  EXPIRY_RESET = TIME_W'(300);

    typedef enum logic [1:0] {
        S_IDLE,
        S_BUSY,
        S_FINISH
    } state_t;

    // Frame header broadcast to every cell while it is in flight.
    typedef struct packed {
        logic [MAC_W-1:0]  src_mac;
        logic [MAC_W-1:0]  dst_mac;
        logic [PORT_W-1:0] in_port;
        logic [TIME_W-1:0] now;
        logic              age_en;
        logic [TIME_W-1:0] limit;
    } item_t;

    // Accumulator handed from cell to cell.
    typedef struct packed {
        logic               active;
        logic [COUNT_W-1:0] count;
        logic               src_hit;
        logic               free_found;
        logic [IDX_W-1:0]   free_idx;
        logic               dst_hit;
        logic [PORT_W-1:0]  dst_port;
    } token_t;

    // New-entry write issued at the end of the sweep.
    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  idx;
        logic [MAC_W-1:0]  addr;
        logic [PORT_W-1:0] port;
        logic [TIME_W-1:0] stamp;
    } learn_wr_t;

endpackage

// ----- rtl/mlbt_cell.sv -----
// One cell of the table chain: holds CELL_ENTRIES entries, ages, searches
// and refreshes them as the token passes. Depends on mlbt_pkg.
module mlbt_cell import mlbt_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [CELL_W-1:0] cell_idx,
    input  item_t             item,
    input  token_t            tok_in,
    input  learn_wr_t         learn_wr,
    output token_t            tok_out
);

    logic [CELL_ENTRIES-1:0] valid_reg;
    logic [MAC_W-1:0]        addr_reg  [CELL_ENTRIES];
    logic [PORT_W-1:0]       port_reg  [CELL_ENTRIES];
    logic [TIME_W-1:0]       stamp_reg [CELL_ENTRIES];
    token_t                  tok_reg;
    token_t                  tok_next;

    logic [CELL_ENTRIES-1:0] live;
    logic [CELL_ENTRIES-1:0] src_m;
    logic [CELL_ENTRIES-1:0] dst_m;
    logic [LCNT_W-1:0]       local_exp;
    logic                    free_any;
    logic [LOCAL_W-1:0]      free_loc;
    logic                    dst_any;
    logic [LOCAL_W-1:0]      dst_loc;
    logic [SUM_W-1:0]        sum;
    logic                    wr_here;

    always_comb begin
        local_exp = '0;
        free_any  = 1'b0;
        free_loc  = '0;
        dst_any   = 1'b0;
        dst_loc   = '0;
        for (int e = 0; e < CELL_ENTRIES; e++) begin
            live[e]  = valid_reg[e] &&
                       !(item.age_en && stamp_reg[e] < item.limit);
            src_m[e] = live[e] && addr_reg[e] == item.src_mac;
            dst_m[e] = live[e] && addr_reg[e] == item.dst_mac;
            local_exp = local_exp + LCNT_W'(valid_reg[e] && !live[e]);
        end
        // downward scan leaves the lowest index
        for (int e = CELL_ENTRIES - 1; e >= 0; e--) begin
            if (!live[e]) begin
                free_any = 1'b1;
                free_loc = LOCAL_W'(e);
            end
            if (dst_m[e]) begin
                dst_any = 1'b1;
                dst_loc = LOCAL_W'(e);
            end
        end

        sum = {1'b0, tok_in.count} + SUM_W'(local_exp);
        tok_next = tok_in;
        tok_next.count   = (sum > SUM_W'(COUNT_MAX)) ? COUNT_MAX : sum[COUNT_W-1:0];
        tok_next.src_hit = tok_in.src_hit || (src_m != '0);
        if (!tok_in.free_found && free_any) begin
            tok_next.free_found = 1'b1;
            tok_next.free_idx   = {cell_idx, free_loc};
        end
        if (!tok_in.dst_hit && dst_any) begin
            tok_next.dst_hit  = 1'b1;
            tok_next.dst_port = port_reg[dst_loc];
        end

        wr_here = learn_wr.en && learn_wr.idx[IDX_W-1:LOCAL_W] == cell_idx;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            tok_reg   <= '0;
        end else begin
            tok_reg <= tok_in.active ? tok_next : '0;
            if (tok_in.active) begin
                valid_reg <= live;
            end
            if (wr_here) begin
                valid_reg[learn_wr.idx[LOCAL_W-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int e = 0; e < CELL_ENTRIES; e++) begin
            if (tok_in.active && src_m[e]) begin
                stamp_reg[e] <= item.now;
            end
        end
        if (wr_here) begin
            addr_reg[learn_wr.idx[LOCAL_W-1:0]]  <= learn_wr.addr;
            port_reg[learn_wr.idx[LOCAL_W-1:0]]  <= learn_wr.port;
            stamp_reg[learn_wr.idx[LOCAL_W-1:0]] <= learn_wr.stamp;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ----- rtl/mac_learning_bridge_table_unit.sv -----
// Top level of the MAC learning bridge table: control FSM, item register
// and the chain of mlbt_cell instances. Depends on mlbt_pkg, assert_macros.svh.
//
// Usage:
//  - s_* channel (valid/ready) takes one frame header beat: source and
//    destination MAC, ingress port, timestamp.
//  - m_* channel (valid/ready) returns one result beat per header: port
//    of the destination (or flood), learned/full flags, aged-out count.
//  - cfg_wr_en/cfg_wr_data write the expiry age; write only while idle.
//  - A header walks a chain of NUM_CELLS cells, one cell per cycle; each
//    cell ages, searches and refreshes its CELL_ENTRIES entries on the way.
//  - Path to a result: the NUM_CELLS chain, then the capture register,
//    then the output register load.
//  - One header at a time: the next header is taken in the cycle the
//    result is loaded.
//  - A result left waiting in the output register blocks the next
//    header: s_ready stays low until that result drains.
//  - Reset: all entries invalid, expiry age 300, both channels empty.
module mac_learning_bridge_table_unit import mlbt_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [TIME_W-1:0]  cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [MAC_W-1:0]   s_src_mac,
    input  logic [MAC_W-1:0]   s_dst_mac,
    input  logic [PORT_W-1:0]  s_in_port,
    input  logic [TIME_W-1:0]  s_now,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [PORT_W-1:0]  m_out_port,
    output logic               m_flood,
    output logic               m_learned_new,
    output logic               m_table_full,
    output logic [COUNT_W-1:0] m_expired_count
);

    state_t             state_reg, state_next;
    logic [TIME_W-1:0]  expiry_reg;
    item_t              item_reg;
    token_t             start_reg;
    token_t             start_next;
    token_t             fin_reg;
    token_t             tok [NUM_CELLS+1];
    learn_wr_t          learn_wr;

    logic               accept;
    logic               out_load;
    logic               learned;
    logic               full;
    logic               self_hit;

    logic               m_valid_reg;
    logic [PORT_W-1:0]  port_reg;
    logic               flood_reg;
    logic               learned_reg;
    logic               full_reg;
    logic [COUNT_W-1:0] count_reg;

    assign tok[0] = start_reg;

    for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
        mlbt_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cell_idx (CELL_W'(i)),
            .item     (item_reg),
            .tok_in   (tok[i]),
            .learn_wr (learn_wr),
            .tok_out  (tok[i+1])
        );
    end

    always_comb begin
        learned  = !fin_reg.src_hit && fin_reg.free_found;
        full     = !fin_reg.src_hit && !fin_reg.free_found;
        // destination is the source that is being learned right now
        self_hit = learned && item_reg.dst_mac == item_reg.src_mac;
    end

    always_comb begin
        state_next = state_reg;
        out_load   = 1'b0;
        s_ready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
            end
            S_BUSY: begin
                if (tok[NUM_CELLS].active) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                out_load = !m_valid_reg || m_ready;
                s_ready  = out_load;
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        accept = s_valid && s_ready;
        if (accept) begin
            state_next = S_BUSY;
        end

        start_next        = '0;
        start_next.active = accept;

        learn_wr.en    = out_load && learned;
        learn_wr.idx   = fin_reg.free_idx;
        learn_wr.addr  = item_reg.src_mac;
        learn_wr.port  = item_reg.in_port;
        learn_wr.stamp = item_reg.now;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            expiry_reg  <= EXPIRY_RESET;
            start_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                expiry_reg <= cfg_wr_data;
            end
            start_reg <= start_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg.src_mac <= s_src_mac;
            item_reg.dst_mac <= s_dst_mac;
            item_reg.in_port <= s_in_port;
            item_reg.now     <= s_now;
            item_reg.age_en  <= s_now >= expiry_reg;
            item_reg.limit   <= s_now - expiry_reg;
        end
        if (tok[NUM_CELLS].active) begin
            fin_reg <= tok[NUM_CELLS];
        end
        if (out_load) begin
            flood_reg   <= !(self_hit || fin_reg.dst_hit);
            port_reg    <= self_hit ? item_reg.in_port :
                           (fin_reg.dst_hit ? fin_reg.dst_port : '0);
            learned_reg <= learned;
            full_reg    <= full;
            count_reg   <= fin_reg.count;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_out_port      = port_reg;
    assign m_flood         = flood_reg;
    assign m_learned_new   = learned_reg;
    assign m_table_full    = full_reg;
    assign m_expired_count = count_reg;

`include "assert_macros.svh"

    `MLBT_ASSERT_NXT(a_accept_busy, s_valid && s_ready, !s_ready && state_reg == S_BUSY)
    `MLBT_ASSERT_IMP(a_tok_when_busy, tok[NUM_CELLS].active, state_reg == S_BUSY)
    `MLBT_ASSERT_IMP(a_flood_port_zero, m_valid && m_flood, m_out_port == '0)
    `MLBT_ASSERT_IMP(a_learn_xor_full, m_valid, !(m_learned_new && m_table_full))

endmodule
